### design/dls_pkg.sv
// Shared types, codes and decode functions for the lexer token scanner.
package dls_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int OUT_W            = 16;

    typedef logic [4:0] state_t;
    typedef logic [4:0] class_t;
    typedef logic [4:0] token_t;

    // Automaton states
    localparam state_t ST_START   = 5'd0;
    localparam state_t ST_FAIL    = 5'd1;
    localparam state_t ST_IDENT   = 5'd2;
    localparam state_t ST_INT     = 5'd3;
    localparam state_t ST_PLUS    = 5'd4;
    localparam state_t ST_MINUS   = 5'd5;
    localparam state_t ST_STAR    = 5'd6;
    localparam state_t ST_CSTART  = 5'd7;
    localparam state_t ST_LT      = 5'd8;
    localparam state_t ST_GT      = 5'd9;
    localparam state_t ST_EQ      = 5'd10;
    localparam state_t ST_DEQ     = 5'd11;
    localparam state_t ST_SDB     = 5'd12;
    localparam state_t ST_EXCL    = 5'd13;
    localparam state_t ST_AND     = 5'd14;
    localparam state_t ST_SEMI    = 5'd15;
    localparam state_t ST_LPAR    = 5'd16;
    localparam state_t ST_RPAR    = 5'd17;
    localparam state_t ST_LBRK    = 5'd18;
    localparam state_t ST_RBRK    = 5'd19;
    localparam state_t ST_LBRC    = 5'd20;
    localparam state_t ST_RBRC    = 5'd21;
    localparam state_t ST_SPACE   = 5'd22;
    localparam state_t ST_CEND    = 5'd23;
    localparam state_t ST_COLON   = 5'd24;
    localparam state_t ST_LTCOLON = 5'd25;
    localparam state_t ST_COMMENT = 5'd26;
    localparam state_t ST_CFINISH = 5'd27;

    // Character classes
    localparam class_t CL_FAIL   = 5'd0;
    localparam class_t CL_LETTER = 5'd1;
    localparam class_t CL_DIGIT  = 5'd2;
    localparam class_t CL_LT     = 5'd3;
    localparam class_t CL_GT     = 5'd4;
    localparam class_t CL_EQ     = 5'd5;
    localparam class_t CL_COLON  = 5'd6;
    localparam class_t CL_BLANK  = 5'd7;
    localparam class_t CL_NL     = 5'd8;
    localparam class_t CL_SLASH  = 5'd9;
    localparam class_t CL_STAR   = 5'd10;
    localparam class_t CL_PLUS   = 5'd11;
    localparam class_t CL_MINUS  = 5'd12;
    localparam class_t CL_EXCL   = 5'd13;
    localparam class_t CL_AND    = 5'd14;
    localparam class_t CL_SEMI   = 5'd15;
    localparam class_t CL_LPAR   = 5'd16;
    localparam class_t CL_RPAR   = 5'd17;
    localparam class_t CL_LBRK   = 5'd18;
    localparam class_t CL_RBRK   = 5'd19;
    localparam class_t CL_LBRC   = 5'd20;
    localparam class_t CL_RBRC   = 5'd21;

    localparam token_t TOK_FAIL  = 5'd0;
    localparam token_t TOK_EMPTY = 5'd21;

    typedef struct packed {
        logic   ok;
        state_t nx;
    } step_t;

    typedef struct packed {
        logic              accepted;
        token_t            token_type;
        logic [OUT_W-1:0]  steps_back;
        logic [OUT_W-1:0]  token_line;
        logic [OUT_W-1:0]  token_column;
    } result_t;

    function automatic class_t classify(input logic [7:0] c);
        class_t cl;
        cl = CL_FAIL;
        if ((c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122))
            cl = CL_LETTER;
        else if (c >= 8'd48 && c <= 8'd57)
            cl = CL_DIGIT;
        else
        begin
            unique case (c)
                8'h3C:   cl = CL_LT;
                8'h3E:   cl = CL_GT;
                8'h3D:   cl = CL_EQ;
                8'h3A:   cl = CL_COLON;
                8'h20, 8'h09, 8'h0D, 8'h0F, 8'h00: cl = CL_BLANK;
                8'h0A:   cl = CL_NL;
                8'h2F:   cl = CL_SLASH;
                8'h2A:   cl = CL_STAR;
                8'h2B:   cl = CL_PLUS;
                8'h2D:   cl = CL_MINUS;
                8'h21:   cl = CL_EXCL;
                8'h26:   cl = CL_AND;
                8'h3B:   cl = CL_SEMI;
                8'h28:   cl = CL_LPAR;
                8'h29:   cl = CL_RPAR;
                8'h5B:   cl = CL_LBRK;
                8'h5D:   cl = CL_RBRK;
                8'h7B:   cl = CL_LBRC;
                8'h7D:   cl = CL_RBRC;
                default: cl = CL_FAIL;
            endcase
        end
        return cl;
    endfunction

    function automatic step_t start_step(input class_t cl);
        step_t s;
        s.ok = 1'b1;
        s.nx = ST_START;
        unique case (cl)
            CL_LETTER: s.nx = ST_IDENT;
            CL_DIGIT:  s.nx = ST_INT;
            CL_LT:     s.nx = ST_LT;
            CL_GT:     s.nx = ST_GT;
            CL_EQ:     s.nx = ST_EQ;
            CL_COLON:  s.nx = ST_COLON;
            CL_BLANK:  s.nx = ST_SPACE;
            CL_NL:     s.nx = ST_SPACE;
            CL_SLASH:  s.nx = ST_CSTART;
            CL_STAR:   s.nx = ST_STAR;
            CL_PLUS:   s.nx = ST_PLUS;
            CL_MINUS:  s.nx = ST_MINUS;
            CL_EXCL:   s.nx = ST_EXCL;
            CL_AND:    s.nx = ST_AND;
            CL_SEMI:   s.nx = ST_SEMI;
            CL_LPAR:   s.nx = ST_LPAR;
            CL_RPAR:   s.nx = ST_RPAR;
            CL_LBRK:   s.nx = ST_LBRK;
            CL_RBRK:   s.nx = ST_RBRK;
            CL_LBRC:   s.nx = ST_LBRC;
            CL_RBRC:   s.nx = ST_RBRC;
            default:   s.ok = 1'b0;
        endcase
        return s;
    endfunction

    function automatic step_t next_step(input state_t st, input class_t cl);
        step_t s;
        s.ok = 1'b0;
        s.nx = ST_START;
        unique case (st)
            ST_START:   s = start_step(cl);
            ST_IDENT:
            begin
                s.ok = (cl == CL_LETTER) || (cl == CL_DIGIT);
                s.nx = ST_IDENT;
            end
            ST_INT:
            begin
                s.ok = (cl == CL_DIGIT);
                s.nx = ST_INT;
            end
            ST_LT:
            begin
                s.ok = (cl == CL_COLON);
                s.nx = ST_LTCOLON;
            end
            ST_COLON:
            begin
                s.ok = (cl == CL_EQ);
                s.nx = ST_DEQ;
            end
            ST_LTCOLON:
            begin
                s.ok = (cl == CL_GT);
                s.nx = ST_SDB;
            end
            ST_CSTART:
            begin
                s.ok = (cl == CL_STAR);
                s.nx = ST_COMMENT;
            end
            ST_COMMENT:
            begin
                s.ok = 1'b1;
                s.nx = (cl == CL_STAR) ? ST_CFINISH : ST_COMMENT;
            end
            ST_CFINISH:
            begin
                s.ok = 1'b1;
                if (cl == CL_STAR)
                    s.nx = ST_CFINISH;
                else if (cl == CL_SLASH)
                    s.nx = ST_CEND;
                else
                    s.nx = ST_COMMENT;
            end
            default:    s.ok = 1'b0;
        endcase
        return s;
    endfunction

    function automatic token_t token_of(input state_t st);
        token_t t;
        if (st >= ST_IDENT && st <= ST_SPACE)
            t = st - 5'd1;
        else if (st == ST_CEND)
            t = TOK_EMPTY;
        else
            t = TOK_FAIL;
        return t;
    endfunction

endpackage

### design/dfa_lexer_token_scanner_core.sv
// Top level of the maximal-munch lexer token scanner.
//
// Takes one source byte per beat and returns one result per byte: accepted=1
// when the lexer automaton consumes it, or a token boundary (type, steps back,
// line, start column) when it does not; the rejected byte is not consumed and
// must be pushed again by the caller together with the pushed-back bytes.
// Sustains one byte per clock cycle while neither queue is full. A byte is
// held in the class queue after the character decode, then passes through
// the automaton step and counter update into the result queue. Both queues
// hold two beats, so each side may stall on its own. Line, column
// and lexeme counters are COUNTER_BITS wide and wrap; results carry their low
// 16 bits. No clearing pass after reset.
module dfa_lexer_token_scanner_core #(
    parameter int COUNTER_BITS = dls_pkg::COUNTER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  character,
    input  logic        push,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic        accepted,
    output logic [4:0]  token_type,
    output logic [15:0] steps_back,
    output logic [15:0] token_line,
    output logic [15:0] token_column
);
    import dls_pkg::*;

    class_t  cls_data;
    logic    cls_empty;
    logic    cls_pop;
    result_t res;

    dls_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .character (character),
        .push      (push),
        .full      (full),
        .cls_pop   (cls_pop),
        .cls_data  (cls_data),
        .cls_empty (cls_empty)
    );

    dls_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_data  (cls_data),
        .cls_empty (cls_empty),
        .cls_pop   (cls_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign accepted     = res.accepted;
    assign token_type   = res.token_type;
    assign steps_back   = res.steps_back;
    assign token_line   = res.token_line;
    assign token_column = res.token_column;

endmodule

### design/dls_fifo.sv
// Small register queue with registered head, used on both sides of the scanner.
module dls_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + (AW+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

### design/dls_front.sv
// Front end: sorts each character into its class and queues the class.
module dls_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      character,
    input  logic            push,
    output logic            full,
    input  logic            cls_pop,
    output dls_pkg::class_t cls_data,
    output logic            cls_empty
);
    import dls_pkg::*;

    class_t cls_in;

    assign cls_in = classify(character);

    dls_fifo #(
        .WIDTH ($bits(class_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls_in),
        .full  (full),
        .pop   (cls_pop),
        .rdata (cls_data),
        .empty (cls_empty)
    );

endmodule

### design/dls_back.sv
// Back end: steps the automaton and position counters, queues the results.
module dls_back #(
    parameter int COUNTER_BITS = dls_pkg::COUNTER_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dls_pkg::class_t  cls_data,
    input  logic             cls_empty,
    output logic             cls_pop,
    input  logic             pop,
    output logic             empty,
    output dls_pkg::result_t res
);
    import dls_pkg::*;

    localparam int CW = COUNTER_BITS;

    state_t        state_reg, state_next;
    state_t        last_reg, last_next;
    logic [CW-1:0] pending_reg, pending_next;
    logic [CW-1:0] line_reg, line_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] lex_reg, lex_next;

    logic          out_full;
    logic          fire;
    step_t         stp;
    result_t       res_in;
    logic [CW-1:0] col_adv, lex_adv, start_col;
    logic [CW+OUT_W-1:0] line_wide, back_wide, scol_wide;

    assign fire    = !cls_empty && !out_full;
    assign cls_pop = fire;
    assign stp     = next_step(state_reg, cls_data);

    always_comb
    begin
        state_next   = state_reg;
        last_next    = last_reg;
        pending_next = pending_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        lex_next     = lex_reg;
        col_adv      = col_reg;
        lex_adv      = lex_reg;
        start_col    = col_reg;

        if (fire)
        begin
            if (stp.ok)
            begin
                state_next = stp.nx;
                if (cls_data == CL_NL)
                begin
                    line_next = line_reg + CW'(1);
                    col_next  = CW'(1);
                end
                else if (stp.nx == ST_CEND)
                begin
                    col_next = col_reg + CW'(1);
                    lex_next = '0;
                end
                else if (cls_data != CL_BLANK)
                begin
                    col_next = col_reg + CW'(1);
                    lex_next = lex_reg + CW'(1);
                end
                else
                    col_next = col_reg + CW'(1);

                if ((stp.nx >= ST_IDENT && stp.nx <= ST_CEND) || stp.nx == ST_COLON)
                begin
                    last_next    = stp.nx;
                    pending_next = '0;
                end
                else if (pending_reg != '1)
                    pending_next = pending_reg + CW'(1);
            end
            else
            begin
                // invalid byte straight from start is consumed into the failed token
                if (cls_data == CL_FAIL && state_reg == ST_START)
                begin
                    col_adv = col_reg + CW'(1);
                    lex_adv = lex_reg + CW'(1);
                end
                if (last_reg != ST_SPACE && last_reg != ST_CEND &&
                    (last_reg != ST_FAIL || state_reg == ST_START))
                    start_col = col_adv - lex_adv;
                else
                    start_col = col_adv;
                state_next   = ST_START;
                last_next    = ST_FAIL;
                col_next     = col_adv - pending_reg;
                pending_next = '0;
                lex_next     = '0;
            end
        end
    end

    // Zero-extend or truncate counters to the result width.
    assign line_wide = {{OUT_W{1'b0}}, line_next};
    assign back_wide = {{OUT_W{1'b0}}, pending_reg};
    assign scol_wide = {{OUT_W{1'b0}}, start_col};

    always_comb
    begin
        res_in.accepted     = stp.ok;
        res_in.token_line   = line_wide[OUT_W-1:0];
        if (stp.ok)
        begin
            res_in.token_type   = TOK_FAIL;
            res_in.steps_back   = '0;
            res_in.token_column = '0;
        end
        else
        begin
            res_in.token_type   = token_of(last_reg);
            res_in.steps_back   = back_wide[OUT_W-1:0];
            res_in.token_column = scol_wide[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_START;
            last_reg    <= ST_FAIL;
            pending_reg <= '0;
            line_reg    <= CW'(1);
            col_reg     <= CW'(1);
            lex_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            pending_reg <= pending_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            lex_reg     <= lex_next;
        end
    end

    dls_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .wdata (res_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (res),
        .empty (empty)
    );

endmodule

### tb/sv/dfa_lexer_token_scanner_core_tb.sv
// Self-checking testbench for the DFA lexer token scanner core, with a closed-loop caller.
module dfa_lexer_token_scanner_core_tb;
    import dls_pkg::*;

    typedef struct packed {
        state_t      st;
        state_t      last;
        logic [15:0] back;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] lexlen;
    } scan_regs_t;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_STALL} rx_mode_t;

    localparam int RANDOM_BYTES = 1500;
    localparam int WRAP_RUN     = 40;
    localparam scan_regs_t SCAN_RESET = '{st: ST_START, last: ST_FAIL, back: 16'd0,
                                          line: 16'd1, col: 16'd1, lexlen: 16'd0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  character = 8'd0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic        accepted;
    logic [4:0]  token_type;
    logic [15:0] steps_back;
    logic [15:0] token_line;
    logic [15:0] token_column;

    logic [7:0] byte_q[$];
    logic [7:0] src_text[$];
    result_t    want_results[$];
    scan_regs_t feed_regs = SCAN_RESET;
    scan_regs_t check_regs = SCAN_RESET;
    int         text_pos = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         cycle_limit = 1000000;
    int         burst_left = 0;
    int         gap_left = 0;
    int         win_left = 0;
    int         stall_left = 0;
    rx_mode_t   rx_mode = RX_STEADY;

    dfa_lexer_token_scanner_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .character    (character),
        .push         (push),
        .full         (full),
        .empty        (empty),
        .pop          (pop),
        .accepted     (accepted),
        .token_type   (token_type),
        .steps_back   (steps_back),
        .token_line   (token_line),
        .token_column (token_column)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic class_t char_class(input logic [7:0] c);
        class_t cl;
        cl = CL_FAIL;
        if ((c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122))
            cl = CL_LETTER;
        else if (c >= 8'd48 && c <= 8'd57)
            cl = CL_DIGIT;
        else
        begin
            case (c)
                "<": cl = CL_LT;
                ">": cl = CL_GT;
                "=": cl = CL_EQ;
                ":": cl = CL_COLON;
                " ", 8'h09, 8'h0D, 8'h0F, 8'h00: cl = CL_BLANK;
                8'h0A: cl = CL_NL;
                "/": cl = CL_SLASH;
                "*": cl = CL_STAR;
                "+": cl = CL_PLUS;
                "-": cl = CL_MINUS;
                "!": cl = CL_EXCL;
                "&": cl = CL_AND;
                ";": cl = CL_SEMI;
                "(": cl = CL_LPAR;
                ")": cl = CL_RPAR;
                "[": cl = CL_LBRK;
                "]": cl = CL_RBRK;
                "{": cl = CL_LBRC;
                "}": cl = CL_RBRC;
                default: cl = CL_FAIL;
            endcase
        end
        return cl;
    endfunction

    function automatic logic scan_next(input state_t st, input class_t cl, output state_t nx);
        logic ok;
        ok = 1'b1;
        nx = st;
        case (st)
            ST_START:
            begin
                case (cl)
                    CL_LETTER: nx = ST_IDENT;
                    CL_DIGIT:  nx = ST_INT;
                    CL_LT:     nx = ST_LT;
                    CL_GT:     nx = ST_GT;
                    CL_EQ:     nx = ST_EQ;
                    CL_COLON:  nx = ST_COLON;
                    CL_BLANK,
                    CL_NL:     nx = ST_SPACE;
                    CL_SLASH:  nx = ST_CSTART;
                    CL_STAR:   nx = ST_STAR;
                    CL_PLUS:   nx = ST_PLUS;
                    CL_MINUS:  nx = ST_MINUS;
                    CL_EXCL:   nx = ST_EXCL;
                    CL_AND:    nx = ST_AND;
                    CL_SEMI:   nx = ST_SEMI;
                    CL_LPAR:   nx = ST_LPAR;
                    CL_RPAR:   nx = ST_RPAR;
                    CL_LBRK:   nx = ST_LBRK;
                    CL_RBRK:   nx = ST_RBRK;
                    CL_LBRC:   nx = ST_LBRC;
                    CL_RBRC:   nx = ST_RBRC;
                    default:   ok = 1'b0;
                endcase
            end
            ST_IDENT:   ok = (cl == CL_LETTER) || (cl == CL_DIGIT);
            ST_INT:     ok = (cl == CL_DIGIT);
            ST_LT:
            begin
                ok = (cl == CL_COLON);
                nx = ST_LTCOLON;
            end
            ST_COLON:
            begin
                ok = (cl == CL_EQ);
                nx = ST_DEQ;
            end
            ST_LTCOLON:
            begin
                ok = (cl == CL_GT);
                nx = ST_SDB;
            end
            ST_CSTART:
            begin
                ok = (cl == CL_STAR);
                nx = ST_COMMENT;
            end
            ST_COMMENT: nx = (cl == CL_STAR) ? ST_CFINISH : ST_COMMENT;
            ST_CFINISH:
            begin
                if (cl == CL_STAR)
                    nx = ST_CFINISH;
                else if (cl == CL_SLASH)
                    nx = ST_CEND;
                else
                    nx = ST_COMMENT;
            end
            default:    ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic token_t token_for(input state_t st);
        token_t t;
        if (st >= ST_IDENT && st <= ST_SPACE)
            t = token_t'(st - 5'd1);
        else if (st == ST_CEND)
            t = TOK_EMPTY;
        else
            t = TOK_FAIL;
        return t;
    endfunction

    // One scanner step: expected result for byte c, next register values in nxt.
    function automatic result_t scan_step(input scan_regs_t cur, input logic [7:0] c,
                                          output scan_regs_t nxt);
        result_t     r;
        class_t      cl;
        state_t      nx;
        logic [15:0] start_col;
        nxt = cur;
        r = '0;
        cl = char_class(c);
        if (scan_next(cur.st, cl, nx))
        begin
            nxt.st = nx;
            if (cl == CL_NL)
            begin
                nxt.line = cur.line + 16'd1;
                nxt.col = 16'd1;
            end
            else
            begin
                nxt.col = cur.col + 16'd1;
                if (nx == ST_CEND)
                    nxt.lexlen = 16'd0;
                else if (cl != CL_BLANK)
                    nxt.lexlen = cur.lexlen + 16'd1;
            end
            // the lone colon counts as an accepting point for the push-back count
            if ((nx >= ST_IDENT && nx <= ST_CEND) || nx == ST_COLON)
            begin
                nxt.last = nx;
                nxt.back = 16'd0;
            end
            else if (cur.back != 16'hFFFF)
                nxt.back = cur.back + 16'd1;
            r.accepted = 1'b1;
            r.token_line = nxt.line;
        end
        else
        begin
            // an invalid byte at the start still takes a column
            if (cl == CL_FAIL && cur.st == ST_START)
            begin
                nxt.col = cur.col + 16'd1;
                nxt.lexlen = cur.lexlen + 16'd1;
            end
            if (cur.last != ST_SPACE && cur.last != ST_CEND &&
                (cur.last != ST_FAIL || cur.st == ST_START))
                start_col = nxt.col - nxt.lexlen;
            else
                start_col = nxt.col;
            r.accepted = 1'b0;
            r.token_type = token_for(cur.last);
            r.steps_back = cur.back;
            r.token_line = cur.line;
            r.token_column = start_col;
            nxt.st = ST_START;
            nxt.last = ST_FAIL;
            nxt.col = nxt.col - cur.back;
            nxt.back = 16'd0;
            nxt.lexlen = 16'd0;
        end
        return r;
    endfunction

    // Queue a byte for the driver and track what the scanner will do with it.
    function automatic result_t push_byte(input logic [7:0] c);
        result_t    r;
        scan_regs_t upd;
        r = scan_step(feed_regs, c, upd);
        feed_regs = upd;
        byte_q.push_back(c);
        return r;
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'd97 : 8'd65) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'd48 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_blank();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0: b = " ";
            1: b = 8'h09;
            2: b = 8'h0D;
            3: b = 8'h0F;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    task automatic add_str(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            src_text.push_back(s[k]);
    endtask

    task automatic add_token();
        int    n;
        int    k;
        string ops;
        ops = "+-*!&;()[]{}=<>/";
        case ($urandom_range(0, 15))
            0, 1, 2, 13:
            begin
                src_text.push_back(rand_letter());
                n = $urandom_range(0, 6);
                for (k = 0; k < n; k++)
                    src_text.push_back(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
            end
            3, 14:
            begin
                n = $urandom_range(1, 5);
                for (k = 0; k < n; k++)
                    src_text.push_back(rand_digit());
            end
            4:  src_text.push_back(ops[$urandom_range(0, ops.len() - 1)]);
            5:  add_str(":=");
            6:  add_str("<:>");
            7:
            begin
                case ($urandom_range(0, 3))
                    0: add_str("<:");
                    1: add_str(":");
                    2: add_str("/");
                    default: add_str("<");
                endcase
            end
            8, 15:
            begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    src_text.push_back(rand_blank());
            end
            9:  src_text.push_back(8'h0A);
            10:
            begin
                add_str("/*");
                n = $urandom_range(0, 8);
                for (k = 0; k < n; k++)
                begin
                    case ($urandom_range(0, 3))
                        0: src_text.push_back("*");
                        1: src_text.push_back(8'h0A);
                        2: src_text.push_back("/");
                        default: src_text.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                if ($urandom_range(0, 2) == 0)
                    add_str("**/");
                else
                    add_str("*/");
            end
            11: src_text.push_back(8'($urandom_range(0, 255)));
            default: src_text.push_back(8'($urandom_range(128, 255)));
        endcase
    endtask

    // Act as the caller: on a boundary, re-send the rejected byte and the pushed-back ones.
    task automatic advance_text();
        result_t r;
        logic    at_start;
        while (text_pos < src_text.size())
        begin
            at_start = (feed_regs.st == ST_START);
            r = push_byte(src_text[text_pos]);
            // skip a byte the start state refuses; now and then drop one like a sloppy caller
            if (r.accepted || at_start || $urandom_range(0, 15) == 0)
                text_pos++;
            else
                text_pos = text_pos - int'(r.steps_back);
            if (text_pos < 0)
                text_pos = 0;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 100)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial
    begin : stimulus
        string opening;
        int    i;
        opening = "Zz0:x<:>:=/*\n**/<:a9";
        for (i = 0; i < opening.len(); i++)
            void'(push_byte(opening[i]));
        void'(push_byte(8'hFF));
        void'(push_byte(8'h80));
        void'(push_byte(8'h00));
        while (byte_q.size() < RANDOM_BYTES + 23)
        begin
            add_token();
            advance_text();
        end
        // long identifier, then a comment full of newlines
        for (i = 0; i < WRAP_RUN; i++)
            src_text.push_back("q");
        add_str(" /*");
        for (i = 0; i < WRAP_RUN; i++)
            src_text.push_back(8'h0A);
        add_str("*/x ");
        advance_text();
        cycle_limit = byte_q.size() * 30 + 10000;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (byte_q.size() != 0 || want_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("dfa_lexer_token_scanner_core test passed");
        else
            $display("dfa_lexer_token_scanner_core test failed");
        $finish;
    end

    // Sender: bursts of random length, random gaps in between.
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 16);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (burst_left > 0)
            begin
                burst_left--;
                if (byte_q.size() != 0)
                begin
                    push <= 1'b1;
                    character <= byte_q[0];
                end
                else
                    push <= 1'b0;
            end
            else
            begin
                gap_left--;
                push <= 1'b0;
            end
        end
    end

    // Receiver: switch between steady, coin-toss and stall-heavy popping.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (win_left == 0)
            begin
                win_left = $urandom_range(4, 40);
                rx_mode = rx_mode_t'($urandom_range(0, 2));
            end
            else
                win_left--;
            case (rx_mode)
                RX_STEADY: pop <= 1'b1;
                RX_COIN:   pop <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        pop <= 1'b0;
                    end
                    else
                    begin
                        stall_left = $urandom_range(1, 8);
                        pop <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Predict each accepted beat in order.
    always @(posedge clk)
    begin : predict
        scan_regs_t upd;
        result_t    r;
        if (rst_n && push && !full)
        begin
            r = scan_step(check_regs, character, upd);
            check_regs = upd;
            want_results.push_back(r);
            void'(byte_q.pop_front());
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (want_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 100)
                    $display("%0t: result beat with nothing expected, actual accepted %0d",
                             $time, accepted);
            end
            else
            begin
                want = want_results.pop_front();
                check_field("accepted", 16'(want.accepted), 16'(accepted));
                check_field("token_type", 16'(want.token_type), 16'(token_type));
                check_field("steps_back", want.steps_back, steps_back);
                check_field("token_line", want.token_line, token_line);
                check_field("token_column", want.token_column, token_column);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("dfa_lexer_token_scanner_core test failed");
            $finish;
        end
    end

endmodule
